### hw/rtl/tsd_pkg.sv
package tsd_pkg;

    // Field widths
    localparam int TodW  = 32;
    localparam int WordW = 30;
    localparam int SecW  = 17;   // whole seconds, up to one full day
    localparam int RemW  = 12;   // seconds within the hour
    localparam int MinW  = 6;
    localparam int HourW = 4;    // 12-hour clock value
    localparam int HrawW = 5;    // 24-hour value, up to 24
    localparam int SegW  = 7;

    // Range and time constants
    localparam logic [TodW-1:0] TodLimit    = 32'd1382400;
    localparam logic [SecW-1:0] SecsPerHour = 17'd3600;
    localparam logic [HrawW-1:0] HalfDay    = 5'd12;
    localparam logic [HourW-1:0] HalfDayH   = 4'd12;
    localparam logic [HourW-1:0] HourTen    = 4'd10;

    // Reciprocal multiply: secs / 3600, exact for secs below 2^17
    localparam int HourShift = 29;
    localparam int HourProdW = SecW + 18;
    localparam logic [HourProdW-1:0] HourRecip = 35'd149131;

    // Reciprocal multiply: rem / 60, exact for rem below 3600
    localparam int MinShift = 18;
    localparam int MinProdW = RemW + 13;
    localparam logic [MinProdW-1:0] MinRecip = 25'd4370;

    // Reciprocal multiply: mins / 10, exact for mins below 60
    localparam int DigShift = 7;
    localparam int DigProdW = 10;
    localparam logic [DigProdW-1:0] DigRecip = 10'd13;
    localparam logic [MinW-1:0] DigTen = 6'd10;

    // Display word bit offsets
    localparam int MinOnesOff = 0;
    localparam int MinTensOff = 7;
    localparam int HrOnesOff  = 14;
    localparam int HrTensOff  = 21;
    localparam int AmBit      = 28;
    localparam int PmBit      = 29;

    // Encoder request: one time value split for display
    typedef struct packed {
        logic [MinW-1:0]  mins;
        logic [HourW-1:0] hour;
        logic             pm;
        logic             err;
    } t_enc_in;

    // Seven-segment pattern for one decimal digit
    function automatic logic [SegW-1:0] seg7(input logic [3:0] digit);
        logic [SegW-1:0] pat;
        unique case (digit)
            4'd0:    pat = 7'd119;
            4'd1:    pat = 7'd36;
            4'd2:    pat = 7'd93;
            4'd3:    pat = 7'd109;
            4'd4:    pat = 7'd46;
            4'd5:    pat = 7'd107;
            4'd6:    pat = 7'd123;
            4'd7:    pat = 7'd37;
            4'd8:    pat = 7'd127;
            4'd9:    pat = 7'd111;
            default: pat = 7'd0;
        endcase
        return pat;
    endfunction

endpackage

### hw/rtl/tsd_in_if.sv
interface tsd_in_if;
    import tsd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [TodW-1:0] time_of_day;

    modport source (output valid, output time_of_day, input ready);
    modport sink   (input valid, input time_of_day, output ready);
endinterface

### hw/rtl/tsd_out_if.sv
interface tsd_out_if;
    import tsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [WordW-1:0] display_word;
    logic             error;

    modport source (output valid, output display_word, output error, input ready);
    modport sink   (input valid, input display_word, input error, output ready);
endinterface

### hw/rtl/tsd_word_enc.sv
module tsd_word_enc (
    input  tsd_pkg::t_enc_in          i_enc,
    output logic [tsd_pkg::WordW-1:0] o_word
);
    import tsd_pkg::*;

    logic [DigProdW-1:0] tens_prod;
    logic [2:0]          min_tens;
    logic [MinW-1:0]     min_ones;
    logic                hr_tens;
    logic [HourW-1:0]    hr_ones;
    logic [WordW-1:0]    word;

    // Split minutes into tens and ones
    assign tens_prod = DigProdW'(i_enc.mins) * DigRecip;
    assign min_tens  = tens_prod[DigShift+2:DigShift];
    assign min_ones  = i_enc.mins - MinW'(min_tens) * DigTen;

    // Split the 12-hour value
    assign hr_tens = (i_enc.hour >= HourTen);
    assign hr_ones = hr_tens ? (i_enc.hour - HourTen) : i_enc.hour;

    // Assemble segments and the AM/PM flag
    always_comb begin
        word = '0;
        word[MinOnesOff +: SegW] = seg7(min_ones[3:0]);
        word[MinTensOff +: SegW] = seg7({1'b0, min_tens});
        word[HrOnesOff  +: SegW] = seg7(hr_ones);
        if (hr_tens) begin
            word[HrTensOff +: SegW] = seg7(4'd1);
        end
        word[AmBit] = ~i_enc.pm;
        word[PmBit] = i_enc.pm;
    end

    // Blank the word on an out-of-range request
    assign o_word = i_enc.err ? '0 : word;

endmodule

### hw/rtl/time_of_day_to_segment_display_unit.sv
// Channel   Dir  Payload                              Handshake
// i_tod     in   time_of_day (32b signed, 1/16 s)    valid / ready
// o_disp    out  display_word (30b), error (1b)      valid / ready
//
// Five register stages: seconds and range check, hour by reciprocal multiply,
// remainder and 12-hour mapping, minute by reciprocal multiply, word encode.
// One request per cycle sustained while o_disp.ready stays high.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
// Each stage has its own ready, so bubbles close up under a stall and a
// stalled request holds in place without loss or repeat.
module time_of_day_to_segment_display_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsd_in_if.sink    i_tod,
    tsd_out_if.source o_disp
);
    import tsd_pkg::*;

    localparam int NStage = 5;

    logic [NStage-1:0] r_vld;
    logic [NStage-1:0] rdy;

    // Stage 0: seconds and range
    logic             r_err0;
    logic [SecW-1:0]  r_secs0;
    logic             n_err0;
    logic [SecW-1:0]  n_secs0;

    // Stage 1: raw hour
    logic             r_err1;
    logic [SecW-1:0]  r_secs1;
    logic [HrawW-1:0] r_hraw1;
    logic [HourProdW-1:0] hour_prod;

    // Stage 2: remainder within the hour and 12-hour value
    logic             r_err2;
    logic [RemW-1:0]  r_rem2;
    logic [HourW-1:0] r_hour2;
    logic             r_pm2;
    logic [SecW-1:0]  hour_secs;
    logic [HourW-1:0] n_hour2;
    logic             n_pm2;

    // Stage 3: minutes
    t_enc_in              r_enc3;
    logic [MinProdW-1:0]  min_prod;

    // Stage 4: output
    logic [WordW-1:0] r_word4;
    logic             r_err4;
    logic [WordW-1:0] enc_word;

    // Per-stage ready: a stage loads when empty or when its successor moves
    assign rdy[4] = ~r_vld[4] | o_disp.ready;
    assign rdy[3] = ~r_vld[3] | rdy[4];
    assign rdy[2] = ~r_vld[2] | rdy[3];
    assign rdy[1] = ~r_vld[1] | rdy[2];
    assign rdy[0] = ~r_vld[0] | rdy[1];

    assign i_tod.ready = rdy[0];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_tod.valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2];
            if (rdy[4]) r_vld[4] <= r_vld[3];
        end
    end

    // Check the range and round to whole seconds
    assign n_err0  = i_tod.time_of_day[TodW-1] |
                     (unsigned'(i_tod.time_of_day) > TodLimit);
    assign n_secs0 = i_tod.time_of_day[SecW+3:4] + SecW'(i_tod.time_of_day[3]);

    // Divide by 3600 through a reciprocal multiply
    assign hour_prod = HourProdW'(r_secs0) * HourRecip;

    // Take the remainder and fold the hour onto a 12-hour clock
    assign hour_secs = SecW'(r_hraw1) * SecsPerHour;

    always_comb begin
        if (r_hraw1 == '0) begin
            n_hour2 = HalfDayH;
            n_pm2   = 1'b0;
        end else if (r_hraw1 < HalfDay) begin
            n_hour2 = r_hraw1[HourW-1:0];
            n_pm2   = 1'b0;
        end else if (r_hraw1 == HalfDay) begin
            n_hour2 = HalfDayH;
            n_pm2   = 1'b1;
        end else begin
            n_hour2 = HourW'(r_hraw1 - HalfDay);
            n_pm2   = 1'b1;
        end
    end

    // Divide the remainder by 60 through a reciprocal multiply
    assign min_prod = MinProdW'(r_rem2) * MinRecip;

    // Encode digits into the display word
    tsd_word_enc u_enc (
        .i_enc  (r_enc3),
        .o_word (enc_word)
    );

    // Stage payload registers
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_err0  <= n_err0;
            r_secs0 <= n_secs0;
        end
        if (rdy[1]) begin
            r_err1  <= r_err0;
            r_secs1 <= r_secs0;
            r_hraw1 <= hour_prod[HourShift+HrawW-1:HourShift];
        end
        if (rdy[2]) begin
            r_err2  <= r_err1;
            r_rem2  <= RemW'(r_secs1 - hour_secs);
            r_hour2 <= n_hour2;
            r_pm2   <= n_pm2;
        end
        if (rdy[3]) begin
            r_enc3.err  <= r_err2;
            r_enc3.mins <= min_prod[MinShift+MinW-1:MinShift];
            r_enc3.hour <= r_hour2;
            r_enc3.pm   <= r_pm2;
        end
        if (rdy[4]) begin
            r_word4 <= enc_word;
            r_err4  <= r_enc3.err;
        end
    end

    assign o_disp.valid        = r_vld[4];
    assign o_disp.display_word = r_word4;
    assign o_disp.error        = r_err4;

`ifndef SYNTH
    a_err_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_disp.valid && o_disp.error) |-> (o_disp.display_word == '0))
        else $error("error result with nonzero display word");

    a_ampm_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_disp.valid && !o_disp.error) |-> $onehot(o_disp.display_word[PmBit:AmBit]))
        else $error("AM/PM flags not exactly one");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !r_enc3.err) |-> (r_enc3.hour >= 4'd1 && r_enc3.hour <= HalfDayH))
        else $error("12-hour value out of range");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tod.valid && i_tod.ready) |=> r_vld[0])
        else $error("accepted request not held in first stage");
`endif

endmodule
